@@ src/lsas_pkg.sv @@
// shared types, constants and ladder tables of the light sensor autorange smoother
// no dependencies
package lsas_pkg;

	localparam int RUNG_W   = 4;
	localparam int COUNT_W  = 16;
	localparam int LUX_W    = 32;
	localparam int WEIGHT_W = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [RUNG_W-1:0] RUNG_COUNT = 4'd10;
	localparam logic [RUNG_W-1:0] RUNG_LAST  = 4'd9;
	localparam logic [RUNG_W-1:0] START_RUNG_DEFAULT = 4'd5;

	localparam logic [COUNT_W-1:0]  LOW_LIMIT_RESET     = 16'd80;
	localparam logic [COUNT_W-1:0]  CEIL_SHORT_RESET    = 16'd33176;
	localparam logic [COUNT_W-1:0]  CEIL_LONG_RESET     = 16'd58981;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET        = 16'd4096;

	localparam logic [1:0] MODE_MEASURE = 2'd0;
	localparam logic [1:0] MODE_PIN     = 2'd1;

	localparam logic [1:0] TIME_100MS = 2'd0;

	typedef enum logic [1:0] {
		REG_LOW_LIMIT  = 2'd0,
		REG_CEIL_SHORT = 2'd1,
		REG_CEIL_LONG  = 2'd2,
		REG_WEIGHT     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED     = 3'd0,
		ST_STEP_DOWN    = 3'd1,
		ST_STEP_UP      = 3'd2,
		ST_LUX_ERROR    = 3'd3,
		ST_PINNED       = 3'd4,
		ST_PIN_REJECTED = 3'd5,
		ST_UNPINNED     = 3'd6
	} status_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  low_count_limit;
		logic [COUNT_W-1:0]  ceiling_short;
		logic [COUNT_W-1:0]  ceiling_long;
		logic [WEIGHT_W-1:0] smoothing_weight;
	} cfg_t;

	typedef struct packed {
		logic [RUNG_W-1:0] rung;
		logic              pinned;
		status_t           status;
		logic              accept;
	} range_res_t;

	function automatic logic [1:0] gain_of_rung(input logic [RUNG_W-1:0] r);
		logic [1:0] g;
		case (r)
			4'd0, 4'd1:       g = 2'd0;
			4'd2, 4'd3:       g = 2'd1;
			4'd4, 4'd5, 4'd6: g = 2'd2;
			4'd7, 4'd8, 4'd9: g = 2'd3;
			default:          g = 2'd0;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] time_of_rung(input logic [RUNG_W-1:0] r);
		logic [1:0] t;
		case (r)
			4'd0, 4'd2, 4'd4: t = 2'd0;
			4'd1, 4'd3, 4'd5, 4'd7: t = 2'd1;
			4'd6, 4'd8:       t = 2'd2;
			4'd9:             t = 2'd3;
			default:          t = 2'd0;
		endcase
		return t;
	endfunction

endpackage

@@ src/lsas_if.sv @@
// valid/ready channel interfaces for measurement beats and result beats
// uses lsas_pkg for field widths
interface lsas_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [lsas_pkg::COUNT_W-1:0]  full_count;
	logic [lsas_pkg::COUNT_W-1:0]  ir_count;
	logic [lsas_pkg::LUX_W-1:0]    lux_value;
	logic                          lux_error;
	logic [lsas_pkg::RUNG_W-1:0]   pin_target;

	modport source (output valid, mode, full_count, ir_count, lux_value, lux_error,
		pin_target, input ready);
	modport sink (input valid, mode, full_count, ir_count, lux_value, lux_error,
		pin_target, output ready);
endinterface

interface lsas_out_if;
	logic                          valid;
	logic                          ready;
	logic [lsas_pkg::RUNG_W-1:0]   rung;
	logic [1:0]                    gain_code;
	logic [1:0]                    integration_code;
	logic [2:0]                    status;
	logic                          is_pinned;
	logic [lsas_pkg::LUX_W-1:0]    raw_lux;
	logic [lsas_pkg::LUX_W-1:0]    smoothed_lux;

	modport source (output valid, rung, gain_code, integration_code, status, is_pinned,
		raw_lux, smoothed_lux, input ready);
	modport sink (input valid, rung, gain_code, integration_code, status, is_pinned,
		raw_lux, smoothed_lux, output ready);
endinterface

@@ src/lsas_cfg_regs.sv @@
// apb register file: low limit, ceilings and smoothing weight
// uses lsas_pkg
module lsas_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lsas_pkg::ADDR_W-1:0]  paddr,
	input  logic [lsas_pkg::DATA_W-1:0]  pwdata,
	output logic [lsas_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output lsas_pkg::cfg_t               cfg
);
	import lsas_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_count_limit  <= LOW_LIMIT_RESET;
			cfg_q.ceiling_short    <= CEIL_SHORT_RESET;
			cfg_q.ceiling_long     <= CEIL_LONG_RESET;
			cfg_q.smoothing_weight <= WEIGHT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_LOW_LIMIT:  cfg_q.low_count_limit  <= pwdata[COUNT_W-1:0];
				REG_CEIL_SHORT: cfg_q.ceiling_short    <= pwdata[COUNT_W-1:0];
				REG_CEIL_LONG:  cfg_q.ceiling_long     <= pwdata[COUNT_W-1:0];
				REG_WEIGHT:     cfg_q.smoothing_weight <= pwdata[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOW_LIMIT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.low_count_limit};
			REG_CEIL_SHORT: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.ceiling_short};
			REG_CEIL_LONG:  prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.ceiling_long};
			REG_WEIGHT:     prdata = {{(DATA_W-WEIGHT_W){1'b0}}, cfg_q.smoothing_weight};
			default:        prdata = '0;
		endcase
	end

endmodule

@@ src/lsas_range_ctrl.sv @@
// rung decision: saturation and dark checks, pin and unpin commands
// uses lsas_pkg
module lsas_range_ctrl (
	input  logic [1:0]                   mode,
	input  logic [lsas_pkg::COUNT_W-1:0] full_count,
	input  logic [lsas_pkg::COUNT_W-1:0] ir_count,
	input  logic                         lux_error,
	input  logic [lsas_pkg::RUNG_W-1:0]  pin_target,
	input  logic [lsas_pkg::RUNG_W-1:0]  rung,
	input  logic                         pinned,
	input  lsas_pkg::cfg_t               cfg,
	output lsas_pkg::range_res_t         res
);
	import lsas_pkg::*;

	logic [COUNT_W-1:0] ceil;
	logic               sat;
	logic               dark;

	assign ceil = (time_of_rung(rung) == TIME_100MS) ? cfg.ceiling_short : cfg.ceiling_long;
	assign sat  = (full_count >= ceil) || (ir_count >= ceil);
	assign dark = full_count < cfg.low_count_limit;

	always_comb begin
		res.rung   = rung;
		res.pinned = pinned;
		res.status = ST_ACCEPTED;
		res.accept = 1'b0;
		if (mode == MODE_PIN) begin
			if (pin_target >= RUNG_COUNT) begin
				res.status = ST_PIN_REJECTED;
			end else begin
				res.rung   = pin_target;
				res.pinned = 1'b1;
				res.status = ST_PINNED;
			end
		end else if (mode[1]) begin
			res.pinned = 1'b0;
			res.status = ST_UNPINNED;
		end else if (!pinned && sat && rung != '0) begin
			res.rung   = rung - 1'b1;
			res.status = ST_STEP_DOWN;
		end else if (!pinned && !sat && dark && rung < RUNG_LAST) begin
			res.rung   = rung + 1'b1;
			res.status = ST_STEP_UP;
		end else if (lux_error) begin
			res.status = ST_LUX_ERROR;
		end else begin
			res.accept = 1'b1;
		end
	end

endmodule

@@ src/lsas_ema.sv @@
// exponential average update with round-half-away rounding of the step
// uses lsas_pkg
module lsas_ema (
	input  logic [lsas_pkg::LUX_W-1:0]    avg,
	input  logic                          seeded,
	input  logic [lsas_pkg::LUX_W-1:0]    lux,
	input  logic [lsas_pkg::WEIGHT_W-1:0] weight,
	output logic [lsas_pkg::LUX_W-1:0]    avg_next
);
	import lsas_pkg::*;

	localparam int PROD_W = LUX_W + WEIGHT_W;

	logic              rising;
	logic [LUX_W-1:0]  diff;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] rnd;
	logic [LUX_W-1:0]  delta;

	assign rising = lux >= avg;
	assign diff   = rising ? (lux - avg) : (avg - lux);
	assign prod   = PROD_W'(diff) * PROD_W'(weight);
	assign rnd    = prod + (PROD_W'(1) << (WEIGHT_W - 1));
	assign delta  = rnd[PROD_W-1:WEIGHT_W];

	always_comb begin
		if (!seeded) begin
			avg_next = lux;
		end else if (rising) begin
			avg_next = avg + delta;
		end else begin
			avg_next = avg - delta;
		end
	end

endmodule

@@ src/light_sensor_autorange_smoother.sv @@
// top level of the light sensor autorange smoother
// uses lsas_pkg, lsas_if, lsas_cfg_regs, lsas_range_ctrl and lsas_ema
//
// meas carries one beat per measurement or command (mode 0 measure, 1 pin,
// 2 or 3 unpin). res returns exactly one beat per meas beat, in order, with
// the rung, its gain and integration codes, a status code, the pin flag and
// the stored raw and averaged lux. Registers sit on the apb port.
// A beat is captured in an input register; the rung logic and the averaging
// multiplier then update the state and load the result register when it can take the beat.
// Throughput is one beat per cycle while res is not stalled; a single 32x16
// multiply sits between the two registers.
// When res is stalled the result register holds and the input register takes
// one more beat, then meas.ready drops until res drains.
// Reset puts the rung at START_RUNG, clears the pin flag, unseeds the average,
// zeroes the stored lux values and loads the register defaults.
module light_sensor_autorange_smoother #(
	parameter logic [lsas_pkg::RUNG_W-1:0] START_RUNG = lsas_pkg::START_RUNG_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lsas_in_if.sink                      meas,
	lsas_out_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lsas_pkg::ADDR_W-1:0]  paddr,
	input  logic [lsas_pkg::DATA_W-1:0]  pwdata,
	output logic [lsas_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import lsas_pkg::*;

	cfg_t             cfg;
	range_res_t       rng;
	logic [LUX_W-1:0] avg_next;

	logic               valid_s1;
	logic [1:0]         mode_s1;
	logic [COUNT_W-1:0] full_s1;
	logic [COUNT_W-1:0] ir_s1;
	logic [LUX_W-1:0]   lux_s1;
	logic               lux_err_s1;
	logic [RUNG_W-1:0]  target_s1;

	logic [RUNG_W-1:0] rung_q;
	logic              pinned_q;
	logic              seeded_q;
	logic [LUX_W-1:0]  avg_q;
	logic [LUX_W-1:0]  raw_q;

	logic              valid_s2;
	logic [RUNG_W-1:0] rung_s2;
	logic [1:0]        gain_s2;
	logic [1:0]        time_s2;
	status_t           status_s2;
	logic              pinned_s2;
	logic [LUX_W-1:0]  raw_s2;
	logic [LUX_W-1:0]  avg_s2;

	logic advance;
	logic [LUX_W-1:0] raw_new;
	logic [LUX_W-1:0] avg_new;

	lsas_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsas_range_ctrl u_range (
		.mode       (mode_s1),
		.full_count (full_s1),
		.ir_count   (ir_s1),
		.lux_error  (lux_err_s1),
		.pin_target (target_s1),
		.rung       (rung_q),
		.pinned     (pinned_q),
		.cfg        (cfg),
		.res        (rng)
	);

	lsas_ema u_ema (
		.avg      (avg_q),
		.seeded   (seeded_q),
		.lux      (lux_s1),
		.weight   (cfg.smoothing_weight),
		.avg_next (avg_next)
	);

	assign advance    = valid_s1 && (!valid_s2 || res.ready);
	assign meas.ready = !valid_s1 || advance;
	assign raw_new    = rng.accept ? lux_s1 : raw_q;
	assign avg_new    = rng.accept ? avg_next : avg_q;

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas.ready && meas.valid) begin
			mode_s1    <= meas.mode;
			full_s1    <= meas.full_count;
			ir_s1      <= meas.ir_count;
			lux_s1     <= meas.lux_value;
			lux_err_s1 <= meas.lux_error;
			target_s1  <= meas.pin_target;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rung_q   <= START_RUNG;
			pinned_q <= 1'b0;
			seeded_q <= 1'b0;
			avg_q    <= '0;
			raw_q    <= '0;
		end else if (advance) begin
			rung_q   <= rng.rung;
			pinned_q <= rng.pinned;
			seeded_q <= seeded_q || rng.accept;
			avg_q    <= avg_new;
			raw_q    <= raw_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rung_s2   <= rng.rung;
			gain_s2   <= gain_of_rung(rng.rung);
			time_s2   <= time_of_rung(rng.rung);
			status_s2 <= rng.status;
			pinned_s2 <= rng.pinned;
			raw_s2    <= raw_new;
			avg_s2    <= avg_new;
		end
	end

	assign res.valid            = valid_s2;
	assign res.rung             = rung_s2;
	assign res.gain_code        = gain_s2;
	assign res.integration_code = time_s2;
	assign res.status           = status_s2;
	assign res.is_pinned        = pinned_s2;
	assign res.raw_lux          = raw_s2;
	assign res.smoothed_lux     = avg_s2;

`ifndef NO_ASSERTIONS
	a_rung_on_ladder: assert property (@(posedge clk) disable iff (!arst_n)
		rung_q <= RUNG_LAST)
		else $error("rung left the ladder");

	a_drop_keeps_raw: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !rng.accept |=> $stable(raw_q) && $stable(avg_q))
		else $error("dropped beat changed stored lux");

	a_pin_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ST_PINNED |-> pinned_s2)
		else $error("pinned status without pin flag");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> meas.ready)
		else $error("input stalled with empty result register");
`endif

endmodule

@@ verif/lsas_checker.sv @@
`timescale 1ns / 1ps
// result checker for light_sensor_autorange_smoother: tracks the register writes and rung ladder,
// predicts every result beat and compares it field by field; uses lsas_pkg and lsas_if
module lsas_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	lsas_in_if                          meas,
	lsas_out_if                         res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [lsas_pkg::ADDR_W-1:0] paddr,
	input  logic [lsas_pkg::DATA_W-1:0] pwdata,
	input  logic [lsas_pkg::DATA_W-1:0] prdata,
	input  logic                        check_end,
	output int                          errors,
	output int                          pending
);
	import lsas_pkg::*;

	typedef struct packed {
		logic [RUNG_W-1:0] rung;
		logic [1:0]        gain;
		logic [1:0]        itime;
		status_t           status;
		logic              pinned;
		logic [LUX_W-1:0]  raw;
		logic [LUX_W-1:0]  avg;
	} ladder_report_t;

	localparam logic [1:0] GAIN_LADDER [10] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
		2'd3, 2'd3, 2'd3};
	localparam logic [1:0] TIME_LADDER [10] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2,
		2'd1, 2'd2, 2'd3};

	cfg_t              regs_now;
	logic [RUNG_W-1:0] rung_now;
	logic              pinned_now;
	logic              avg_seeded;
	logic [LUX_W-1:0]  avg_now;
	logic [LUX_W-1:0]  raw_now;

	ladder_report_t reports_due[$];
	ladder_report_t want;
	ladder_report_t made;
	logic [DATA_W-1:0] reg_now;
	int fail_count = 0;
	int due_count = 0;
	logic end_checked = 1'b0;

	assign errors = fail_count;
	assign pending = due_count;

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s mismatch: got %0h, want %0h", name, got, exp_val));
	endtask

	task automatic fold_into_average(input logic [LUX_W-1:0] lux);
		logic [63:0] prod;
		raw_now = lux;
		if (!avg_seeded) begin
			avg_now = lux;
			avg_seeded = 1'b1;
		end else if (lux >= avg_now) begin
			prod = 64'(lux - avg_now) * 64'(regs_now.smoothing_weight) + 64'd32768;
			avg_now = avg_now + prod[47:16];
		end else begin
			prod = 64'(avg_now - lux) * 64'(regs_now.smoothing_weight) + 64'd32768;
			avg_now = avg_now - prod[47:16];
		end
	endtask

	task automatic advance_ladder(output ladder_report_t r);
		logic [COUNT_W-1:0] ceil_val;
		logic stepped;
		status_t st;
		stepped = 1'b0;
		st = ST_ACCEPTED;
		if (meas.mode == MODE_PIN) begin
			if (meas.pin_target >= RUNG_COUNT) begin
				st = ST_PIN_REJECTED;
			end else begin
				rung_now = meas.pin_target;
				pinned_now = 1'b1;
				st = ST_PINNED;
			end
		end else if (meas.mode != MODE_MEASURE) begin
			pinned_now = 1'b0;
			st = ST_UNPINNED;
		end else begin
			if (!pinned_now) begin
				ceil_val = (TIME_LADDER[rung_now] == TIME_100MS) ? regs_now.ceiling_short
					: regs_now.ceiling_long;
				if (meas.full_count >= ceil_val || meas.ir_count >= ceil_val) begin
					if (rung_now != '0) begin
						rung_now = rung_now - 1'b1;
						st = ST_STEP_DOWN;
						stepped = 1'b1;
					end
				end else if (meas.full_count < regs_now.low_count_limit
					&& rung_now != RUNG_LAST) begin
					rung_now = rung_now + 1'b1;
					st = ST_STEP_UP;
					stepped = 1'b1;
				end
			end
			if (!stepped) begin
				if (meas.lux_error) begin
					st = ST_LUX_ERROR;
				end else begin
					fold_into_average(meas.lux_value);
					st = ST_ACCEPTED;
				end
			end
		end
		r.rung = rung_now;
		r.gain = GAIN_LADDER[rung_now];
		r.itime = TIME_LADDER[rung_now];
		r.status = st;
		r.pinned = pinned_now;
		r.raw = raw_now;
		r.avg = avg_now;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_now = '{LOW_LIMIT_RESET, CEIL_SHORT_RESET, CEIL_LONG_RESET, WEIGHT_RESET};
			rung_now = START_RUNG_DEFAULT;
			pinned_now = 1'b0;
			avg_seeded = 1'b0;
			avg_now = '0;
			raw_now = '0;
			reports_due.delete();
			due_count = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[3:2]))
						REG_LOW_LIMIT:  regs_now.low_count_limit = pwdata[15:0];
						REG_CEIL_SHORT: regs_now.ceiling_short = pwdata[15:0];
						REG_CEIL_LONG:  regs_now.ceiling_long = pwdata[15:0];
						REG_WEIGHT:     regs_now.smoothing_weight = pwdata[15:0];
						default:        ;
					endcase
				end else begin
					case (reg_idx_t'(paddr[3:2]))
						REG_LOW_LIMIT:  reg_now = 32'(regs_now.low_count_limit);
						REG_CEIL_SHORT: reg_now = 32'(regs_now.ceiling_short);
						REG_CEIL_LONG:  reg_now = 32'(regs_now.ceiling_long);
						default:        reg_now = 32'(regs_now.smoothing_weight);
					endcase
					check_field($sformatf("register read at %0h", paddr), prdata, reg_now);
				end
			end
			if (res.valid && res.ready) begin
				if (due_count == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = reports_due.pop_front();
					due_count--;
					check_field("rung", 32'(res.rung), 32'(want.rung));
					check_field("gain_code", 32'(res.gain_code), 32'(want.gain));
					check_field("integration_code", 32'(res.integration_code), 32'(want.itime));
					check_field("status", 32'(res.status), 32'(want.status));
					check_field("is_pinned", 32'(res.is_pinned), 32'(want.pinned));
					check_field("raw_lux", res.raw_lux, want.raw);
					check_field("smoothed_lux", res.smoothed_lux, want.avg);
				end
			end
			if (meas.valid && meas.ready) begin
				advance_ladder(made);
				reports_due.push_back(made);
				due_count++;
			end
			if (check_end && !end_checked) begin
				end_checked = 1'b1;
				if (due_count != 0)
					report($sformatf("%0d results never arrived", due_count));
			end
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for light_sensor_autorange_smoother: directed ladder corner cases, then
// random beats over several register settings; uses lsas_pkg, lsas_if, the block and lsas_checker
module tb;
	import lsas_pkg::*;

	localparam logic [1:0] MODE_UNPIN     = 2'd2;
	localparam logic [1:0] MODE_UNPIN_ALT = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              check_end = 1'b0;
	int                errors;
	int                pending;
	int                burst_left = 0;
	int                rx_left = 0;
	int                rx_style = 0;
	cfg_t              regs_set;

	lsas_in_if  meas_ch();
	lsas_out_if res_ch();

	always #6 clk = ~clk;

	light_sensor_autorange_smoother i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_ch),
		.res    (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	lsas_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.meas     (meas_ch),
		.res      (res_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.check_end(check_end),
		.errors   (errors),
		.pending  (pending)
	);

	// result side stalls in styles of its own, from always ready to mostly stalled
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_left = $urandom_range(10, 200);
		end else begin
			rx_left--;
		end
		case (rx_style)
			0:       res_ch.ready <= 1'b1;
			1:       res_ch.ready <= 1'($urandom_range(0, 1));
			2:       res_ch.ready <= ($urandom_range(0, 4) == 0);
			default: res_ch.ready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	initial begin
		#10_000_000;
		$display("FAIL light_sensor_autorange_smoother");
		$finish;
	end

	task automatic send_beat(input logic [1:0] mode, input logic [15:0] full,
		input logic [15:0] ir, input logic [31:0] lux, input logic err, input logic [3:0] target);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				meas_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		meas_ch.valid <= 1'b1;
		meas_ch.mode <= mode;
		meas_ch.full_count <= full;
		meas_ch.ir_count <= ir;
		meas_ch.lux_value <= lux;
		meas_ch.lux_error <= err;
		meas_ch.pin_target <= target;
		do @(posedge clk); while (!meas_ch.ready);
		burst_left--;
	endtask

	task automatic hold_until_drained();
		meas_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] low, input logic [15:0] cs,
		input logic [15:0] cl, input logic [15:0] w);
		regs_set = '{low, cs, cl, w};
		apb_access(1'b1, REG_LOW_LIMIT, low);
		apb_access(1'b1, REG_CEIL_SHORT, cs);
		apb_access(1'b1, REG_CEIL_LONG, cl);
		apb_access(1'b1, REG_WEIGHT, w);
		read_config();
	endtask

	task automatic read_config();
		apb_access(1'b0, REG_LOW_LIMIT, '0);
		apb_access(1'b0, REG_CEIL_SHORT, '0);
		apb_access(1'b0, REG_CEIL_LONG, '0);
		apb_access(1'b0, REG_WEIGHT, '0);
	endtask

	function automatic logic [15:0] near_value(input logic [15:0] base);
		int v;
		v = int'(base) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	// counts cluster around the limits that move the rung
	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 7))
			0, 1:    return 16'($urandom);
			2, 7:    return near_value(regs_set.low_count_limit);
			3:       return near_value(regs_set.ceiling_short);
			4:       return near_value(regs_set.ceiling_long);
			5:       return 16'($urandom_range(0, 255));
			default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_lux();
		case ($urandom_range(0, 4))
			0:       return 32'($urandom_range(0, 1023));
			1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 1023));
			2:       return {16'($urandom), 16'h0000};
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				send_beat(MODE_MEASURE, pick_count(), pick_count(), pick_lux(),
					($urandom_range(0, 9) == 0), 4'($urandom));
			else if (pick < 91)
				send_beat(MODE_PIN, 16'($urandom), 16'($urandom), $urandom,
					1'($urandom), 4'($urandom_range(0, 12)));
			else
				send_beat(($urandom_range(0, 1) != 0) ? MODE_UNPIN : MODE_UNPIN_ALT,
					16'($urandom), 16'($urandom), $urandom, 1'($urandom), 4'($urandom));
		end
	endtask

	// default registers, rung starts at 5 on a long integration time
	task automatic directed_items();
		send_beat(MODE_MEASURE, 16'd1000, 16'd100, 32'h0001_0000, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd1000, 16'd100, 32'h0008_0000, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd1000, 16'd100, 32'h0002_0000, 1'b1, 4'd0);
		send_beat(MODE_MEASURE, 16'd58981, 16'd0, 32'h0003_0000, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd100, 16'd33176, 32'h0003_0000, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd79, 16'd0, 32'h0003_0000, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd80, 16'd33175, 32'hFFFF_FFFF, 1'b0, 4'd0);
		send_beat(MODE_PIN, 16'd0, 16'd0, 32'd0, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'hFFFF, 16'hFFFF, 32'd0, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd500, 16'd0, 32'h0000_1234, 1'b1, 4'd0);
		send_beat(MODE_PIN, 16'd0, 16'd0, 32'd0, 1'b0, 4'd10);
		send_beat(MODE_PIN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_beat(MODE_UNPIN, 16'd0, 16'd0, 32'd0, 1'b0, 4'd0);
		send_beat(MODE_UNPIN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
		send_beat(MODE_MEASURE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd0, 16'hFFFF, 32'h0000_1234, 1'b0, 4'd0);
		send_beat(MODE_PIN, 16'd0, 16'd0, 32'd0, 1'b0, 4'd9);
		send_beat(MODE_UNPIN_ALT, 16'd0, 16'd0, 32'd0, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd0, 16'd0, 32'd0, 1'b0, 4'd0);
		send_beat(MODE_MEASURE, 16'd0, 16'd0, 32'h5555_AAAA, 1'b1, 4'd0);
		send_beat(MODE_MEASURE, 16'hFFFF, 16'd0, 32'hAAAA_5555, 1'b0, 4'd15);
		send_beat(MODE_PIN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd5);
		send_beat(MODE_MEASURE, 16'd0, 16'd0, 32'h7FFF_FFFF, 1'b0, 4'd15);
		send_beat(MODE_UNPIN_ALT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
	endtask

	initial begin
		meas_ch.valid = 1'b0;
		meas_ch.mode = MODE_MEASURE;
		meas_ch.full_count = '0;
		meas_ch.ir_count = '0;
		meas_ch.lux_value = '0;
		meas_ch.lux_error = 1'b0;
		meas_ch.pin_target = '0;
		res_ch.ready = 1'b0;
		regs_set = '{LOW_LIMIT_RESET, CEIL_SHORT_RESET, CEIL_LONG_RESET, WEIGHT_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_config();
		directed_items();
		random_items(300);
		hold_until_drained();
		random_items(100);
		hold_until_drained();
		write_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		random_items(300);
		hold_until_drained();
		write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		random_items(300);
		hold_until_drained();
		write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'd1);
		random_items(300);
		hold_until_drained();
		write_config(16'd1000, 16'd20000, 16'd40000, 16'd32768);
		random_items(400);
		hold_until_drained();
		write_config(LOW_LIMIT_RESET, CEIL_SHORT_RESET, CEIL_LONG_RESET, WEIGHT_RESET);
		random_items(300);
		hold_until_drained();
		repeat (10) @(posedge clk);
		check_end <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("PASS light_sensor_autorange_smoother");
		else
			$display("FAIL light_sensor_autorange_smoother");
		$finish;
	end

endmodule

@@ light_sensor_autorange_smoother.f @@
src/lsas_pkg.sv
src/lsas_if.sv
src/lsas_cfg_regs.sv
src/lsas_range_ctrl.sv
src/lsas_ema.sv
src/light_sensor_autorange_smoother.sv
verif/lsas_checker.sv
verif/tb.sv
